@@ design/gadf_pkg.sv @@
// gadf_pkg: shared types, constants and decode functions of the axis deadzone filter
// depends on nothing; used by every module of the block

package gadf_pkg;

    // widths of the fields
    localparam int AXIS_W  = 3;
    localparam int VAL_W   = 16;
    localparam int DZ_W    = 15;
    localparam int WIN_W   = 8;
    localparam int PAD_W   = 4;
    localparam int KEY_W   = 2;

    // axes that have a deadzone register, and the default axis count
    localparam int REG_COUNT      = 6;
    localparam int AXIS_COUNT_DEF = 6;

    // entries of the job queue between front and back
    localparam int JOB_DEPTH = 4;

    // register indexes of the configuration port
    localparam logic [AXIS_W-1:0] REG_DZ_LX = 3'd0;
    localparam logic [AXIS_W-1:0] REG_DZ_LY = 3'd1;
    localparam logic [AXIS_W-1:0] REG_DZ_LZ = 3'd2;
    localparam logic [AXIS_W-1:0] REG_DZ_RX = 3'd3;
    localparam logic [AXIS_W-1:0] REG_DZ_RY = 3'd4;
    localparam logic [AXIS_W-1:0] REG_DZ_RZ = 3'd5;

    // deadzone values after reset
    localparam logic [DZ_W-1:0] DZ_LEFT_STICK_RST  = 15'd7849;
    localparam logic [DZ_W-1:0] DZ_RIGHT_STICK_RST = 15'd8689;
    localparam logic [DZ_W-1:0] DZ_TRIGGER_RST     = 15'd30;

    // event kinds
    localparam logic EVT_AXIS = 1'b0;
    localparam logic EVT_KEY  = 1'b1;

    // key codes
    localparam logic [KEY_W-1:0] KEY_LEFT  = 2'd0;
    localparam logic [KEY_W-1:0] KEY_RIGHT = 2'd1;
    localparam logic [KEY_W-1:0] KEY_UP    = 2'd2;
    localparam logic [KEY_W-1:0] KEY_DOWN  = 2'd3;

    // axis classes
    localparam logic [1:0] AK_X = 2'd0;
    localparam logic [1:0] AK_Y = 2'd1;
    localparam logic [1:0] AK_Z = 2'd2;

    typedef logic [DZ_W-1:0] t_deadzone;

    typedef struct packed {
        logic [AXIS_W-1:0]       axis_index;
        logic signed [VAL_W-1:0] raw_value;
        logic [WIN_W-1:0]        window_id;
        logic [PAD_W-1:0]        pad_id;
    } t_item;

    typedef struct packed {
        logic                    event_kind;
        logic [AXIS_W-1:0]       event_axis;
        logic signed [VAL_W-1:0] filtered_value;
        logic [KEY_W-1:0]        key_code;
        logic                    key_down;
        logic [WIN_W-1:0]        out_window;
        logic [PAD_W-1:0]        out_pad;
        logic                    last_of_run;
    } t_event;

    // one changed sample, handed from front to back
    typedef struct packed {
        logic [AXIS_W-1:0]       axis;
        logic [1:0]              kind;
        logic signed [VAL_W-1:0] value;
        logic [WIN_W-1:0]        window;
        logic [PAD_W-1:0]        pad;
    } t_job;

    // reset value of deadzone register idx
    function automatic t_deadzone dz_reset(input logic [AXIS_W-1:0] idx);
        t_deadzone v;
        unique case (idx) inside
            REG_DZ_LX, REG_DZ_LY: v = DZ_LEFT_STICK_RST;
            REG_DZ_RX, REG_DZ_RY: v = DZ_RIGHT_STICK_RST;
            default:              v = DZ_TRIGGER_RST;
        endcase
        return v;
    endfunction

    // class of an axis; axes past the register list behave as triggers
    function automatic logic [1:0] axis_kind(input logic [AXIS_W-1:0] axis);
        logic [1:0] k;
        unique case (axis) inside
            REG_DZ_LX, REG_DZ_RX: k = AK_X;
            REG_DZ_LY, REG_DZ_RY: k = AK_Y;
            default:              k = AK_Z;
        endcase
        return k;
    endfunction

endpackage

@@ design/gadf_front.sv @@
// gadf_front: deadzone filter, per-axis last-value store and change detection
// depends on gadf_pkg; feeds gadf_queue with one job per changed sample

module gadf_front #(
    parameter int AXIS_COUNT = gadf_pkg::AXIS_COUNT_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_accept,
    input  gadf_pkg::t_item                          i_item,
    input  gadf_pkg::t_deadzone [gadf_pkg::REG_COUNT-1:0] i_deadzone,
    output logic                                     o_job_push,
    output gadf_pkg::t_job                           o_job
);
    import gadf_pkg::*;

    logic signed [VAL_W-1:0] r_last [AXIS_COUNT];

    t_deadzone               dz;
    logic signed [VAL_W:0]   raw_ext;
    logic signed [VAL_W:0]   dz_ext;
    logic                    beyond;
    logic signed [VAL_W-1:0] value;
    logic signed [VAL_W-1:0] last;
    logic                    in_range;
    logic                    changed;

    // deadzone of the sampled axis, zero past the register list
    always_comb begin
        dz = '0;
        for (int i = 0; i < REG_COUNT; i++) begin
            if (i_item.axis_index == AXIS_W'(i)) begin
                dz = i_deadzone[i];
            end
        end
    end

    // keep the sample only when strictly outside +/- deadzone
    assign raw_ext = {i_item.raw_value[VAL_W-1], i_item.raw_value};
    assign dz_ext  = $signed({2'b00, dz});
    assign beyond  = (raw_ext > dz_ext) || (raw_ext < -dz_ext);
    assign value   = beyond ? i_item.raw_value : '0;

    // stored value of the sampled axis
    always_comb begin
        last = '0;
        for (int i = 0; i < AXIS_COUNT; i++) begin
            if (i_item.axis_index == AXIS_W'(i)) begin
                last = r_last[i];
            end
        end
    end

    assign in_range   = {1'b0, i_item.axis_index} < (AXIS_W + 1)'(AXIS_COUNT);
    assign changed    = in_range && (value != last);
    assign o_job_push = i_accept && changed;

    assign o_job.axis   = i_item.axis_index;
    assign o_job.kind   = axis_kind(i_item.axis_index);
    assign o_job.value  = value;
    assign o_job.window = i_item.window_id;
    assign o_job.pad    = i_item.pad_id;

    // last-value store, updated on every changed transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < AXIS_COUNT; i++) begin
                r_last[i] <= '0;
            end
        end else if (o_job_push) begin
            for (int i = 0; i < AXIS_COUNT; i++) begin
                if (i_item.axis_index == AXIS_W'(i)) begin
                    r_last[i] <= value;
                end
            end
        end
    end

    // a job never carries a value equal to what was stored for its axis
    a_job_changes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_push |-> (o_job.value != last))
        else $error("front pushed an unchanged value");

    // store follows the pushed value
    a_store_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_push |=> (last == $past(o_job.value)) || (i_item.axis_index != $past(o_job.axis)))
        else $error("last-value store not updated");

    // out-of-range axes never produce a job
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_push |-> ({1'b0, o_job.axis} < (AXIS_W + 1)'(AXIS_COUNT)))
        else $error("job for an axis past the axis count");

endmodule

@@ design/gadf_queue.sv @@
// gadf_queue: short job queue between front and back
// depends on gadf_pkg for the job type and depth

module gadf_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  gadf_pkg::t_job  i_job,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output gadf_pkg::t_job  o_job
);
    import gadf_pkg::*;

    localparam int PW = $clog2(JOB_DEPTH);

    t_job          r_mem [JOB_DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [PW:0]   r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == (PW + 1)'(JOB_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= r_count + (PW + 1)'(do_push) - (PW + 1)'(do_pop);
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    // front only pushes while there is room
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("job pushed into a full queue");

    // fill count agrees with the pointers
    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr - r_rd) == r_count[PW-1:0])
        else $error("queue pointers and fill count disagree");

endmodule

@@ design/gadf_back.sv @@
// gadf_back: expands each job into its axis and key events, one per cycle unless pop stalls
// depends on gadf_pkg; reads jobs from gadf_queue, drives the result register

module gadf_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_job_valid,
    input  gadf_pkg::t_job  i_job,
    output logic            o_job_pop,
    input  logic            i_pop,
    output logic            o_empty,
    output gadf_pkg::t_event o_event
);
    import gadf_pkg::*;

    localparam logic [1:0] STEP_AXIS = 2'd0;
    localparam logic [1:0] STEP_KEY1 = 2'd1;
    localparam logic [1:0] STEP_KEY2 = 2'd2;

    logic [1:0] r_step;
    logic [1:0] n_step;
    logic       r_valid;
    t_event     r_event;

    t_event         evt;
    logic           advance;
    logic [KEY_W-1:0] first_key;
    logic [KEY_W-1:0] second_key;
    logic           is_zero;

    assign first_key  = (i_job.kind == AK_X) ? KEY_LEFT : KEY_UP;
    assign second_key = (i_job.kind == AK_X) ? KEY_RIGHT : KEY_DOWN;
    assign is_zero    = (i_job.value == '0);

    // event for the current step of the head job
    always_comb begin
        evt                = '0;
        evt.event_axis     = i_job.axis;
        evt.out_window     = i_job.window;
        evt.out_pad        = i_job.pad;
        unique case (r_step)
            STEP_AXIS: begin
                evt.event_kind     = EVT_AXIS;
                evt.filtered_value = i_job.value;
                evt.last_of_run    = (i_job.kind == AK_Z);
            end
            STEP_KEY1: begin
                evt.event_kind  = EVT_KEY;
                evt.key_code    = (is_zero || i_job.value < 0) ? first_key : second_key;
                evt.key_down    = !is_zero;
                evt.last_of_run = !is_zero;
            end
            STEP_KEY2: begin
                evt.event_kind  = EVT_KEY;
                evt.key_code    = second_key;
                evt.key_down    = 1'b0;
                evt.last_of_run = 1'b1;
            end
            default: begin
                evt.last_of_run = 1'b1;
            end
        endcase
    end

    // one event per cycle while the result register is free or draining
    assign advance   = i_job_valid && (!r_valid || i_pop);
    assign o_job_pop = advance && evt.last_of_run;
    assign n_step    = evt.last_of_run ? STEP_AXIS : r_step + 2'd1;

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_AXIS;
        end else if (advance) begin
            r_step <= n_step;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (advance) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_event <= evt;
        end
    end

    assign o_empty = !r_valid;
    assign o_event = r_event;

    // a job is only released on its final event
    a_pop_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_pop |-> (advance && evt.last_of_run))
        else $error("job released before its last event");

    // third step only happens for a zero value on a stick axis
    a_key2_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_job_valid && r_step == STEP_KEY2) |-> (is_zero && i_job.kind != AK_Z))
        else $error("release pair step on a non-zero or trigger job");

    // key steps never run for trigger axes
    a_trigger_axis_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_job_valid && i_job.kind == AK_Z) |-> (r_step == STEP_AXIS))
        else $error("key step on a trigger axis");

    // a stalled event with a pending head is not overwritten
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_pop) |=> $stable(r_step))
        else $error("step advanced while result stalled");

endmodule

@@ design/gamepad_axis_deadzone_filter_unit.sv @@
// gamepad_axis_deadzone_filter_unit: top level, deadzone registers and wiring
// depends on gadf_pkg, gadf_front, gadf_queue, gadf_back
//
//  channel   handshake                  payload
//  -------   -------------------------  -------------------------------
//  sample    push / full                i_item  (gadf_pkg::t_item)
//  event     pop / empty                o_event (gadf_pkg::t_event)
//  config    i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
//  a sample is filtered and compared in the cycle of its transfer; one sample per cycle
//  is taken while the four-entry job queue has room
//  the back emits one event per cycle unless pop stalls, so a changed stick sample gives
//  2 or 3 events, a trigger 1, an unchanged 0; the emitter sets the sustained rate
//  reset clears the value store, queue and result register and restores the deadzones
//  a stall on pop fills the queue and then raises full; config is always ready

module gamepad_axis_deadzone_filter_unit #(
    parameter int AXIS_COUNT = gadf_pkg::AXIS_COUNT_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         push,
    output logic                         full,
    input  gadf_pkg::t_item              i_item,
    input  logic                         pop,
    output logic                         empty,
    output gadf_pkg::t_event             o_event,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [gadf_pkg::AXIS_W-1:0]  i_cfg_index,
    input  logic [gadf_pkg::DZ_W-1:0]    i_cfg_data
);
    import gadf_pkg::*;

    t_deadzone [REG_COUNT-1:0] r_deadzone;

    logic accept;
    logic job_push;
    t_job front_job;
    logic q_full;
    logic q_empty;
    t_job head_job;
    logic job_pop;

    // deadzone registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < REG_COUNT; i++) begin
                r_deadzone[i] <= dz_reset(AXIS_W'(i));
            end
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_DZ_LX: r_deadzone[0] <= i_cfg_data;
                REG_DZ_LY: r_deadzone[1] <= i_cfg_data;
                REG_DZ_LZ: r_deadzone[2] <= i_cfg_data;
                REG_DZ_RX: r_deadzone[3] <= i_cfg_data;
                REG_DZ_RY: r_deadzone[4] <= i_cfg_data;
                REG_DZ_RZ: r_deadzone[5] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // sample transfer
    assign full   = q_full;
    assign accept = push && !q_full;

    gadf_front #(
        .AXIS_COUNT (AXIS_COUNT)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_item     (i_item),
        .i_deadzone (r_deadzone),
        .o_job_push (job_push),
        .o_job      (front_job)
    );

    gadf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (job_pop),
        .o_empty (q_empty),
        .o_job   (head_job)
    );

    gadf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (!q_empty),
        .i_job       (head_job),
        .o_job_pop   (job_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_event     (o_event)
    );

endmodule
